// ----- rtl/core/circular_deque_top_assert.svh -----
// assertion macros for the circular deque
`ifndef CIRCULAR_DEQUE_TOP_ASSERT_SVH
`define CIRCULAR_DEQUE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CDQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/cdq_pkg.sv -----
// types and codes shared by the circular deque modules
package cdq_pkg;

   localparam int DATA_W = 32;

   typedef logic [DATA_W-1:0] data_type;
   typedef logic [2:0]        req_kind_type;
   typedef logic [1:0]        status_type;

   localparam req_kind_type REQ_PUSH_FRONT = 3'd0;
   localparam req_kind_type REQ_PUSH_REAR  = 3'd1;
   localparam req_kind_type REQ_POP_FRONT  = 3'd2;
   localparam req_kind_type REQ_POP_REAR   = 3'd3;
   localparam req_kind_type REQ_PEEK_FRONT = 3'd4;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_OVERFLOW  = 2'd1;
   localparam status_type ST_UNDERFLOW = 2'd2;

endpackage

// ----- rtl/core/cdq_store.sv -----
// entry store: one write port, one read port with registered read data
module cdq_store #(
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  cdq_pkg::data_type        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output cdq_pkg::data_type        rd_data
);

   cdq_pkg::data_type mem [DEPTH];
   cdq_pkg::data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/circular_deque_top.sv -----
// circular deque top level: pointer control, entry store and result register
//
// A double-ended queue of DEPTH unsigned 32-bit entries. Each request pushes at
// either end, pops from either end or peeks at the front, and returns one
// result with a status, the popped or peeked value and the empty and full
// flags after the request. Sustained rate is one request per cycle: the head,
// tail and empty registers update in the cycle a request is taken, and the
// store does one access per request, so the pointer update loop and the store
// ports set that figure. A result goes from the store read register to the
// output register and is held in that register until taken; a request is
// taken while a result waits, and the input stalls only when a further
// result would have nowhere to go. No clearing pass follows reset.
`include "circular_deque_top_assert.svh"

module circular_deque_top #(
   parameter int DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic [2:0]  req_tuser,   // req_type[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // data_out[31:0], is_empty[32], is_full[33], zero fill
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
      return (i == LAST_IDX) ? '0 : AW'(i + 1'b1);
   endfunction

   function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
      return (i == '0) ? LAST_IDX : AW'(i - 1'b1);
   endfunction

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic          empty_ff, empty_in;
   logic          full_now, full_after;

   logic                 busy_ff, busy_in;
   logic                 pend_rd_ff, pend_rd_in;
   cdq_pkg::status_type  pend_status_ff, pend_status_in;
   logic                 pend_empty_ff, pend_empty_in;
   logic                 pend_full_ff, pend_full_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   cdq_pkg::status_type  rsp_status_ff, rsp_status_in;
   cdq_pkg::data_type    rsp_data_ff, rsp_data_in;
   logic                 rsp_empty_ff, rsp_empty_in;
   logic                 rsp_full_ff, rsp_full_in;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   cdq_pkg::data_type rd_data;

   logic req_fire, drain, out_free;
   cdq_pkg::req_kind_type req_kind;

   assign req_kind   = req_tuser;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign drain      = busy_ff && out_free;
   assign req_tready = !busy_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   assign full_now   = !empty_ff && (idx_next(tail_ff) == head_ff);
   assign full_after = !empty_in && (idx_next(tail_in) == head_in);

   // request decode and pointer update
   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      empty_in       = empty_ff;
      wr_en          = 1'b0;
      wr_addr        = '0;
      rd_en          = 1'b0;
      rd_addr        = '0;
      pend_rd_in     = 1'b0;
      pend_status_in = cdq_pkg::ST_OK;
      if (req_fire) begin
         case (req_kind)
            cdq_pkg::REQ_PUSH_FRONT, cdq_pkg::REQ_PUSH_REAR: begin
               if (full_now) begin
                  pend_status_in = cdq_pkg::ST_OVERFLOW;
               end else if (empty_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b0;
                  wr_en    = 1'b1;
                  wr_addr  = '0;
               end else if (req_kind == cdq_pkg::REQ_PUSH_FRONT) begin
                  head_in = idx_prev(head_ff);
                  wr_en   = 1'b1;
                  wr_addr = idx_prev(head_ff);
               end else begin
                  tail_in = idx_next(tail_ff);
                  wr_en   = 1'b1;
                  wr_addr = idx_next(tail_ff);
               end
            end
            cdq_pkg::REQ_POP_FRONT, cdq_pkg::REQ_POP_REAR: begin
               if (empty_ff) begin
                  pend_status_in = cdq_pkg::ST_UNDERFLOW;
               end else begin
                  rd_en      = 1'b1;
                  pend_rd_in = 1'b1;
                  rd_addr    = (req_kind == cdq_pkg::REQ_POP_FRONT) ? head_ff : tail_ff;
                  if (head_ff == tail_ff) begin
                     empty_in = 1'b1;
                  end else if (req_kind == cdq_pkg::REQ_POP_FRONT) begin
                     head_in = idx_next(head_ff);
                  end else begin
                     tail_in = idx_prev(tail_ff);
                  end
               end
            end
            cdq_pkg::REQ_PEEK_FRONT: begin
               if (empty_ff) begin
                  pend_status_in = cdq_pkg::ST_UNDERFLOW;
               end else begin
                  rd_en      = 1'b1;
                  pend_rd_in = 1'b1;
                  rd_addr    = head_ff;
               end
            end
            default: begin
            end
         endcase
      end
      pend_empty_in = empty_in;
      pend_full_in  = full_after;
   end

   // pending stage and output register
   always_comb begin
      busy_in       = busy_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (drain) begin
         busy_in       = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_status_ff;
         rsp_data_in   = pend_rd_ff ? rd_data : '0;
         rsp_empty_in  = pend_empty_ff;
         rsp_full_in   = pend_full_ff;
      end
      if (req_fire) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pend_rd_ff     <= pend_rd_in;
         pend_status_ff <= pend_status_in;
         pend_empty_ff  <= pend_empty_in;
         pend_full_ff   <= pend_full_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
   end

   cdq_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'b0, rsp_full_ff, rsp_empty_ff, rsp_data_ff};

   `CDQ_ASSERT_NOW(a_flags_exclusive, clock, reset, rsp_valid_ff,
      !(rsp_empty_ff && rsp_full_ff), "result reports both empty and full")
   `CDQ_ASSERT_NOW(a_underflow_clean, clock, reset,
      rsp_valid_ff && (rsp_status_ff == cdq_pkg::ST_UNDERFLOW),
      (rsp_data_ff == '0) && rsp_empty_ff, "underflow result with data or not empty")
   `CDQ_ASSERT_NEXT(a_push_fills, clock, reset,
      req_fire && !full_now &&
      ((req_kind == cdq_pkg::REQ_PUSH_FRONT) || (req_kind == cdq_pkg::REQ_PUSH_REAR)),
      !empty_ff, "deque empty after an accepted push")

endmodule
